/* design/rgb_color_cycle_generator_defines.svh */
// Assertion macros shared by the RTL of the color cycle generator.
`ifndef RGB_COLOR_CYCLE_GENERATOR_DEFINES_SVH
`define RGB_COLOR_CYCLE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define RCCG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("rccg assertion failed");
`define RCCG_ASSERT_NEVER(lbl, clk, rstn, cond) \
	`RCCG_ASSERT(lbl, clk, rstn, !(cond))
`else
`define RCCG_ASSERT(lbl, clk, rstn, prop)
`define RCCG_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* design/rccg_pkg.sv */
`default_nettype none

package rccg_pkg;

	localparam int PALETTE_DEPTH = 16;
	localparam int SEGMENT_COUNT = 9;
	localparam int FIELD_SLOTS   = 5;
	localparam int TABLE_SIZE    = PALETTE_DEPTH + FIELD_SLOTS;
	localparam int TAB_AW        = $clog2(TABLE_SIZE);
	localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
	localparam int PAL_IW        = $clog2(PALETTE_DEPTH);
	localparam int IDX_W         = (PAL_IW > 3) ? PAL_IW : 3;
	localparam int SEG_W         = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;

	localparam int PERIOD_MIN = 1000;
	localparam int PERIOD_MAX = 120000;

	localparam logic [23:0] FIELD_DEFAULT = 24'hB8C2D1;
	localparam logic [23:0] UNIFIED_RESET = 24'hB8C2D1;
	localparam logic [16:0] PERIOD_RESET  = 17'd6000;
	localparam logic [4:0]  COUNT_RESET   = 5'd3;

	// {elapsed, 16 fraction bits} / period, four quotient bits per step
	localparam int DIV_BITS     = 48;
	localparam int DIV_PER_STEP = 4;
	localparam int DIV_STEPS    = DIV_BITS / DIV_PER_STEP;
	localparam int DIV_CW       = $clog2(DIV_STEPS);

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		CM_UNIFIED,
		CM_FIELD,
		CM_PALETTE,
		CM_RAINBOW
	} color_mode_t;

	typedef enum logic [1:0] {
		REG_COLOR_MODE,
		REG_PERIOD_MS,
		REG_PALETTE_COUNT,
		REG_UNIFIED_COLOR
	} reg_idx_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] elapsed_ms;
		logic        reduced_motion;
		logic [4:0]  entry_index;
		logic [23:0] entry_color;
	} cmd_item_t;

	typedef struct packed {
		logic [3:0] segment_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} color_item_t;

	// microcode
	typedef logic [3:0] pc_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_DIV,
		OP_SCALE,
		OP_NONE,
		OP_LOAD_A,
		OP_LOAD_B,
		OP_BLEND_R,
		OP_BLEND_G,
		OP_BLEND_B,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		AS_I,
		AS_J,
		AS_FIELD
	} addr_sel_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_NO_TICK,
		C_DIV_MORE,
		C_NO_BLEND,
		C_EMIT
	} cond_t;

	typedef struct packed {
		op_t       op;
		addr_sel_t asel;
		cond_t     cond;
		pc_t       target;
	} ucode_t;

	localparam pc_t STEP_IDLE     = 4'd0;
	localparam pc_t STEP_DIV      = 4'd1;
	localparam pc_t STEP_SCALE    = 4'd2;
	localparam pc_t STEP_RD_A     = 4'd3;
	localparam pc_t STEP_RD_B     = 4'd4;
	localparam pc_t STEP_LOAD_B   = 4'd5;
	localparam pc_t STEP_BLEND_R  = 4'd6;
	localparam pc_t STEP_BLEND_G  = 4'd7;
	localparam pc_t STEP_BLEND_B  = 4'd8;
	localparam pc_t STEP_EMIT_RD  = 4'd9;
	localparam pc_t STEP_EMIT_OUT = 4'd10;

	function automatic ucode_t ucode_rom(pc_t pc);
		ucode_t w;
		case (pc)
			STEP_IDLE:     w = '{OP_IDLE,    AS_FIELD, C_NO_TICK,  STEP_IDLE};
			STEP_DIV:      w = '{OP_DIV,     AS_FIELD, C_DIV_MORE, STEP_DIV};
			STEP_SCALE:    w = '{OP_SCALE,   AS_FIELD, C_NO_BLEND, STEP_EMIT_RD};
			STEP_RD_A:     w = '{OP_NONE,    AS_I,     C_NEXT,     STEP_IDLE};
			STEP_RD_B:     w = '{OP_LOAD_A,  AS_J,     C_NEXT,     STEP_IDLE};
			STEP_LOAD_B:   w = '{OP_LOAD_B,  AS_J,     C_NEXT,     STEP_IDLE};
			STEP_BLEND_R:  w = '{OP_BLEND_R, AS_FIELD, C_NEXT,     STEP_IDLE};
			STEP_BLEND_G:  w = '{OP_BLEND_G, AS_FIELD, C_NEXT,     STEP_IDLE};
			STEP_BLEND_B:  w = '{OP_BLEND_B, AS_FIELD, C_NEXT,     STEP_IDLE};
			STEP_EMIT_RD:  w = '{OP_NONE,    AS_FIELD, C_NEXT,     STEP_IDLE};
			STEP_EMIT_OUT: w = '{OP_EMIT,    AS_FIELD, C_EMIT,     STEP_EMIT_RD};
			default:       w = '{OP_NONE,    AS_FIELD, C_NO_TICK,  STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [23:0] tab_reset(logic [TAB_AW-1:0] a);
		logic [23:0] c;
		if (int'(a) >= PALETTE_DEPTH) begin
			c = FIELD_DEFAULT;
		end else begin
			case (int'(a))
				0:       c = 24'hFF4D4D;
				1:       c = 24'h4DFF80;
				2:       c = 24'h4D99FF;
				default: c = 24'h000000;
			endcase
		end
		return c;
	endfunction

	function automatic logic [23:0] hue_stop(logic [2:0] i);
		logic [23:0] c;
		case (i)
			3'd0:    c = 24'hFF0000;
			3'd1:    c = 24'hFFFF00;
			3'd2:    c = 24'h00FF00;
			3'd3:    c = 24'h00FFFF;
			3'd4:    c = 24'h0000FF;
			3'd5:    c = 24'hFF00FF;
			default: c = 24'hFF0000;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* design/rgb_color_cycle_generator.sv */
// Color generator for nine display segments.
// cmd channel (cmd_valid/cmd_stall/cmd_data): mode 1 writes entry_color into
//   the color table (palette slots, then five field slots); mode 0 is a
//   tick that yields one color per segment.
// color channel (color_valid/color_stall/color_data): the segment colors of
//   a tick in order 0..8, last set on the final one.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while the block is idle.
// Sequence: a tick runs the radix-16 divider that forms the phase, then a
//   step scaling it, then steps fetching and blending the two end colors
//   (palette and rainbow modes only), then a read step and an emit step
//   per segment.
// cmd_stall is high from the tick transfer until the last segment color is
//   loaded into the output register. A stall on the color channel holds the
//   output register and the sequencer waits on its emit step.
// Reset restores the register defaults and makes every table entry read as
//   its default color until written; no clearing pass is needed.
`default_nettype none

`include "rgb_color_cycle_generator_defines.svh"

module rgb_color_cycle_generator
	import rccg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire cmd_item_t   cmd_data,
	output logic             color_valid,
	input  wire logic        color_stall,
	output color_item_t      color_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	// configuration
	color_mode_t color_mode_q;
	logic [16:0] period_q;
	logic [4:0]  count_q;
	logic [23:0] unified_q;

	// sequencer
	pc_t                pc_q, pc_nxt;
	ucode_t             uc;
	logic [DIV_CW-1:0]  div_cnt_q;
	logic [SEG_W-1:0]   seg_q;
	logic               seg_last;

	// datapath
	logic [DIV_BITS-1:0] dd_q, dd_nxt;
	logic [16:0]         rem_q, rem_nxt;
	logic [15:0]         quo_q, quo_nxt;
	logic                rm_q;
	logic [IDX_W-1:0]    idx_i_q, idx_j_q;
	logic [15:0]         frac_q;
	logic [23:0]         a_q, b_q, common_q;

	// table
	logic [23:0]       mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] vld_q;
	logic [TAB_AW-1:0] rd_addr;
	logic [23:0]       rd_data_q, rd_def_q, tab_rd;
	logic              rd_vld_q;

	logic             out_valid_q;
	color_item_t      out_q;

	logic              tick_acc, wr_acc, out_free, do_emit;
	logic [16:0]       psat;
	logic [CNT_W-1:0]  cnt_sat;
	logic [15:0]       phase;
	logic [16+CNT_W-1:0] pmul;
	logic [CNT_W-1:0]  pi, pj;
	logic [18:0]       hmul;
	logic [2:0]        hi, hj;
	logic [2:0]        fld;
	logic [7:0]        a8, b8, blend8;
	logic signed [8:0]  diff;
	logic signed [25:0] prod;
	logic signed [9:0]  bsum;
	logic [23:0]       emit_color;

	assign uc        = ucode_rom(pc_q);
	assign cmd_stall = (pc_q != STEP_IDLE);
	assign tick_acc  = cmd_valid && !cmd_stall && (cmd_data.mode == CMD_TICK);
	assign wr_acc    = cmd_valid && !cmd_stall && (cmd_data.mode == CMD_WRITE);
	assign out_free  = !out_valid_q || !color_stall;
	assign do_emit   = (uc.op == OP_EMIT) && out_free;
	assign seg_last  = (seg_q == SEG_W'(SEGMENT_COUNT - 1));
	assign cfg_ready = 1'b1;

	assign color_valid = out_valid_q;
	assign color_data  = out_q;

	// saturated configuration
	always_comb begin
		if (int'(period_q) < PERIOD_MIN) begin
			psat = 17'(PERIOD_MIN);
		end else if (int'(period_q) > PERIOD_MAX) begin
			psat = 17'(PERIOD_MAX);
		end else begin
			psat = period_q;
		end
		if (int'(count_q) < 2) begin
			cnt_sat = CNT_W'(2);
		end else if (int'(count_q) > PALETTE_DEPTH) begin
			cnt_sat = CNT_W'(PALETTE_DEPTH);
		end else begin
			cnt_sat = CNT_W'(count_q);
		end
	end

	// restoring division, DIV_PER_STEP quotient bits per cycle
	always_comb begin
		logic [17:0] t;
		dd_nxt  = dd_q;
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		for (int k = 0; k < DIV_PER_STEP; k++) begin
			t      = {rem_nxt, dd_nxt[DIV_BITS-1]};
			dd_nxt = {dd_nxt[DIV_BITS-2:0], 1'b0};
			if (t >= {1'b0, psat}) begin
				t       = t - {1'b0, psat};
				quo_nxt = {quo_nxt[14:0], 1'b1};
			end else begin
				quo_nxt = {quo_nxt[14:0], 1'b0};
			end
			rem_nxt = t[16:0];
		end
	end

	// phase scaling to segment index and fraction
	always_comb begin
		phase = rm_q ? 16'h0000 : quo_q;
		pmul  = (16 + CNT_W)'(phase) * (16 + CNT_W)'(cnt_sat);
		pi    = pmul[16 +: CNT_W];
		if (pi >= cnt_sat) begin
			pi = cnt_sat - CNT_W'(1);
		end
		pj = pi + CNT_W'(1);
		if (pj >= cnt_sat) begin
			pj = '0;
		end
		hmul = 19'(phase) * 19'd6;
		hi   = hmul[18:16];
		if (hi > 3'd5) begin
			hi = 3'd5;
		end
		hj = hi + 3'd1;
	end

	// table read address
	always_comb begin
		fld = (int'(seg_q >> 1) > FIELD_SLOTS - 1) ? 3'(FIELD_SLOTS - 1) : 3'(seg_q >> 1);
		case (uc.asel)
			AS_I:     rd_addr = TAB_AW'(idx_i_q);
			AS_J:     rd_addr = TAB_AW'(idx_j_q);
			AS_FIELD: rd_addr = TAB_AW'(PALETTE_DEPTH) + TAB_AW'(fld);
			default:  rd_addr = TAB_AW'(idx_i_q);
		endcase
	end

	assign tab_rd = rd_vld_q ? rd_data_q : rd_def_q;

	// one channel blend: a + ((b - a) * f) >>> 16, which equals the truncated mix
	always_comb begin
		case (uc.op)
			OP_BLEND_G: begin
				a8 = a_q[15:8];
				b8 = b_q[15:8];
			end
			OP_BLEND_B: begin
				a8 = a_q[7:0];
				b8 = b_q[7:0];
			end
			default: begin
				a8 = a_q[23:16];
				b8 = b_q[23:16];
			end
		endcase
		diff   = $signed({1'b0, b8}) - $signed({1'b0, a8});
		prod   = 26'(diff) * 26'($signed({1'b0, frac_q}));
		bsum   = $signed({2'b00, a8}) + $signed(prod[25:16]);
		blend8 = bsum[7:0];
	end

	assign emit_color = (color_mode_q == CM_FIELD) ? tab_rd : common_q;

	// sequencer next step
	always_comb begin
		case (uc.cond)
			C_NEXT:     pc_nxt = pc_q + pc_t'(1);
			C_NO_TICK:  pc_nxt = tick_acc ? pc_q + pc_t'(1) : uc.target;
			C_DIV_MORE: pc_nxt = (div_cnt_q != DIV_CW'(DIV_STEPS - 1)) ? uc.target
			                                                         : pc_q + pc_t'(1);
			C_NO_BLEND: pc_nxt = (color_mode_q == CM_UNIFIED || color_mode_q == CM_FIELD) ?
			                     uc.target : pc_q + pc_t'(1);
			C_EMIT: begin
				if (!out_free) begin
					pc_nxt = pc_q;
				end else if (seg_last) begin
					pc_nxt = STEP_IDLE;
				end else begin
					pc_nxt = uc.target;
				end
			end
			default:    pc_nxt = STEP_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= STEP_IDLE;
			div_cnt_q    <= '0;
			seg_q        <= '0;
			out_valid_q  <= 1'b0;
			vld_q        <= '0;
			color_mode_q <= CM_UNIFIED;
			period_q     <= PERIOD_RESET;
			count_q      <= COUNT_RESET;
			unified_q    <= UNIFIED_RESET;
		end else begin
			pc_q <= pc_nxt;
			if (tick_acc) begin
				div_cnt_q <= '0;
			end else if (uc.op == OP_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CW'(1);
			end
			if (do_emit) begin
				seg_q       <= seg_last ? '0 : seg_q + SEG_W'(1);
				out_valid_q <= 1'b1;
			end else if (!color_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr_acc && int'(cmd_data.entry_index) < TABLE_SIZE) begin
				vld_q[TAB_AW'(cmd_data.entry_index)] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_COLOR_MODE:    color_mode_q <= color_mode_t'(cfg_data[1:0]);
					REG_PERIOD_MS:     period_q     <= cfg_data[16:0];
					REG_PALETTE_COUNT: count_q      <= cfg_data[4:0];
					REG_UNIFIED_COLOR: unified_q    <= cfg_data;
					default:           ;
				endcase
			end
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_acc && int'(cmd_data.entry_index) < TABLE_SIZE) begin
			mem[TAB_AW'(cmd_data.entry_index)] <= cmd_data.entry_color;
		end
		rd_data_q <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
		rd_def_q  <= tab_reset(rd_addr);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			dd_q  <= {cmd_data.elapsed_ms, 16'h0000};
			rem_q <= '0;
			quo_q <= '0;
			rm_q  <= cmd_data.reduced_motion;
		end
		case (uc.op)
			OP_DIV: begin
				dd_q  <= dd_nxt;
				rem_q <= rem_nxt;
				quo_q <= quo_nxt;
			end
			OP_SCALE: begin
				common_q <= unified_q;
				if (color_mode_q == CM_RAINBOW) begin
					idx_i_q <= IDX_W'(hi);
					idx_j_q <= IDX_W'(hj);
					frac_q  <= hmul[15:0];
				end else begin
					idx_i_q <= IDX_W'(pi);
					idx_j_q <= IDX_W'(pj);
					frac_q  <= pmul[15:0];
				end
			end
			OP_LOAD_A: a_q <= (color_mode_q == CM_RAINBOW) ? hue_stop(idx_i_q[2:0]) : tab_rd;
			OP_LOAD_B: b_q <= (color_mode_q == CM_RAINBOW) ? hue_stop(idx_j_q[2:0]) : tab_rd;
			OP_BLEND_R: common_q[23:16] <= blend8;
			OP_BLEND_G: common_q[15:8]  <= blend8;
			OP_BLEND_B: common_q[7:0]   <= blend8;
			default: ;
		endcase
		if (do_emit) begin
			out_q.segment_index <= 4'(seg_q);
			out_q.red           <= emit_color[23:16];
			out_q.green         <= emit_color[15:8];
			out_q.blue          <= emit_color[7:0];
			out_q.last          <= seg_last;
		end
	end

	`RCCG_ASSERT(a_tick_starts_div, clk, arst_n, tick_acc |=> (pc_q == STEP_DIV))
	`RCCG_ASSERT(a_idle_after_last, clk, arst_n, (pc_q == STEP_IDLE && $past(pc_q) == STEP_EMIT_OUT) |-> (out_valid_q && out_q.last))
	`RCCG_ASSERT_NEVER(a_pal_idx_range, clk, arst_n, pc_q == STEP_RD_A && color_mode_q == CM_PALETTE && (CNT_W + IDX_W)'(idx_i_q) >= (CNT_W + IDX_W)'(cnt_sat))

endmodule

`default_nettype wire
